/* src/hcd_pkg.sv */
package hcd_pkg;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [0:0] {
        REG_SIZE_LIMIT   = 1'b0,
        REG_FWD_TRAILERS = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        K_PAYLOAD  = 3'd0,
        K_TRAILER  = 3'd1,
        K_LINE_END = 3'd2,
        K_COMPLETE = 3'd3,
        K_FRAMING  = 3'd4,
        K_OVER     = 3'd5
    } kind_t;

    typedef enum logic [9:0] {
        PH_SIZE    = 10'b00_0000_0001,
        PH_EXT     = 10'b00_0000_0010,
        PH_HDR_LF  = 10'b00_0000_0100,
        PH_DATA    = 10'b00_0000_1000,
        PH_DATA_CR = 10'b00_0001_0000,
        PH_DATA_LF = 10'b00_0010_0000,
        PH_TRAILER = 10'b00_0100_0000,
        PH_TRL_LF  = 10'b00_1000_0000,
        PH_DONE    = 10'b01_0000_0000,
        PH_ERROR   = 10'b10_0000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
    } result_t;

    // bit 4 set when the byte is a hex digit, low nibble is its value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

/* src/hcd_in_reg.sv */
module hcd_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hcd_pkg::in_item_t in_item,
    input  logic              take,
    output logic              held_valid,
    output hcd_pkg::in_item_t held_item
);
    import hcd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

/* src/hcd_parser.sv */
module hcd_parser #(
    parameter int unsigned SIZE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                take,
    input  hcd_pkg::in_item_t                   item,
    input  logic [hcd_pkg::CFG_DATA_W-1:0]      size_limit,
    input  logic                                forward_trailers,
    output logic                                res_valid,
    output hcd_pkg::result_t                    res,
    output hcd_pkg::phase_t                     phase
);
    import hcd_pkg::*;

    localparam int unsigned LIM_W = (SIZE_BITS > CFG_DATA_W) ? SIZE_BITS : CFG_DATA_W;

    phase_t               phase_reg, phase_next;
    logic [SIZE_BITS-1:0] chunk_reg, chunk_next;
    logic [3:0]           digits_reg, digits_next;
    logic                 empty_reg, empty_next;

    phase_t               eff_phase;
    logic [SIZE_BITS-1:0] eff_chunk;
    logic [3:0]           eff_digits;
    logic                 eff_empty;

    logic [LIM_W-1:0]     lim_wide;
    logic [SIZE_BITS-1:0] lim;
    logic [SIZE_BITS-1:0] shifted;
    logic [SIZE_BITS-1:0] chunk_dec;
    logic [4:0]           hex;
    logic [7:0]           c;

    assign phase = phase_reg;
    assign c     = item.data;
    assign hex   = hex_decode(c);

    // effective limit is the smaller of the register and what the counter holds
    assign lim_wide = (LIM_W'(size_limit) < LIM_W'({SIZE_BITS{1'b1}}))
                      ? LIM_W'(size_limit) : LIM_W'({SIZE_BITS{1'b1}});
    assign lim       = lim_wide[SIZE_BITS-1:0];
    assign shifted   = {eff_chunk[SIZE_BITS-5:0], hex[3:0]};
    assign chunk_dec = eff_chunk - SIZE_BITS'(1);

    always_comb
    begin
        eff_phase  = item.first ? PH_SIZE : phase_reg;
        eff_chunk  = item.first ? '0 : chunk_reg;
        eff_digits = item.first ? 4'd0 : digits_reg;
        eff_empty  = item.first ? 1'b1 : empty_reg;
    end

    always_comb
    begin
        phase_next  = eff_phase;
        chunk_next  = eff_chunk;
        digits_next = eff_digits;
        empty_next  = eff_empty;
        res_valid   = 1'b0;
        res.data    = 8'd0;
        res.kind    = K_PAYLOAD;
        case (eff_phase)
            PH_SIZE:
            begin
                if (hex[4])
                begin
                    if (eff_chunk > (lim >> 4) || shifted > lim)
                    begin
                        phase_next = PH_ERROR;
                        res_valid  = 1'b1;
                        res.kind   = K_OVER;
                    end
                    else
                    begin
                        chunk_next = shifted;
                        if (eff_digits != 4'hF)
                        begin
                            digits_next = eff_digits + 4'd1;
                        end
                    end
                end
                else if (eff_digits == 4'd0)
                begin
                    phase_next = PH_ERROR;
                    res_valid  = 1'b1;
                    res.kind   = K_FRAMING;
                end
                else if (c inside {CH_SP, CH_TAB, CH_SEMI})
                begin
                    phase_next = PH_EXT;
                end
                else if (c == CH_CR)
                begin
                    phase_next = PH_HDR_LF;
                end
                else
                begin
                    phase_next = PH_ERROR;
                    res_valid  = 1'b1;
                    res.kind   = K_FRAMING;
                end
            end
            PH_EXT:
            begin
                if (c == CH_CR)
                begin
                    phase_next = PH_HDR_LF;
                end
            end
            PH_HDR_LF:
            begin
                if (c != CH_LF)
                begin
                    phase_next = PH_ERROR;
                    res_valid  = 1'b1;
                    res.kind   = K_FRAMING;
                end
                else if (eff_chunk == '0)
                begin
                    phase_next = PH_TRAILER;
                    empty_next = 1'b1;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                chunk_next = chunk_dec;
                if (chunk_dec == '0)
                begin
                    phase_next = PH_DATA_CR;
                end
                res_valid = 1'b1;
                res.data  = c;
                res.kind  = K_PAYLOAD;
            end
            PH_DATA_CR:
            begin
                if (c != CH_CR)
                begin
                    phase_next = PH_ERROR;
                    res_valid  = 1'b1;
                    res.kind   = K_FRAMING;
                end
                else
                begin
                    phase_next = PH_DATA_LF;
                end
            end
            PH_DATA_LF:
            begin
                if (c != CH_LF)
                begin
                    phase_next = PH_ERROR;
                    res_valid  = 1'b1;
                    res.kind   = K_FRAMING;
                end
                else
                begin
                    phase_next  = PH_SIZE;
                    chunk_next  = '0;
                    digits_next = 4'd0;
                end
            end
            PH_TRAILER:
            begin
                if (c == CH_CR)
                begin
                    phase_next = PH_TRL_LF;
                end
                else
                begin
                    empty_next = 1'b0;
                    res_valid  = forward_trailers;
                    res.data   = c;
                    res.kind   = K_TRAILER;
                end
            end
            PH_TRL_LF:
            begin
                if (c != CH_LF)
                begin
                    phase_next = PH_ERROR;
                    res_valid  = 1'b1;
                    res.kind   = K_FRAMING;
                end
                else if (eff_empty)
                begin
                    phase_next = PH_DONE;
                    res_valid  = 1'b1;
                    res.kind   = K_COMPLETE;
                end
                else
                begin
                    empty_next = 1'b1;
                    phase_next = PH_TRAILER;
                    res_valid  = forward_trailers;
                    res.kind   = K_LINE_END;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIZE;
            chunk_reg  <= '0;
            digits_reg <= 4'd0;
            empty_reg  <= 1'b1;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            chunk_reg  <= chunk_next;
            digits_reg <= digits_next;
            empty_reg  <= empty_next;
        end
    end

endmodule

/* src/hcd_out_reg.sv */
module hcd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  hcd_pkg::result_t res,
    output logic             advance,
    output logic             out_valid,
    input  logic             out_ready,
    output hcd_pkg::result_t out_res
);
    import hcd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // the stage can take a new result when empty or being drained this cycle
    assign advance   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

/* src/http_chunked_deframer.sv */
// Byte-serial decoder for an HTTP/1.1 chunked body. An item is registered on entry,
// parsed by the size/phase logic when it is taken from that register, and its result,
// if any, lands in the output register; a new byte is taken every cycle while out_ready
// holds. Payload bytes come out as kind 0, trailer bytes and line ends as kinds 1 and 2
// (dropped when forward_trailers is 0), then one message-complete; framing faults and
// oversize chunks report once and the parser then ignores bytes until first_byte marks a
// new body. Chunk sizes are held in SIZE_BITS bits and checked against size_limit digit
// by digit.
module http_chunked_deframer #(
    parameter int unsigned SIZE_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [0:0]                         cfg_index,
    input  logic [hcd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         in_byte,
    input  logic                               first_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         out_byte,
    output hcd_pkg::kind_t                     kind
);
    import hcd_pkg::*;

    logic [CFG_DATA_W-1:0] size_limit_reg;
    logic                  fwd_reg;

    in_item_t in_item;
    in_item_t held_item;
    logic     held_valid;
    logic     advance;
    logic     take;
    logic     res_valid;
    result_t  res;
    result_t  out_res;
    phase_t   phase;

    assign in_item.data  = in_byte;
    assign in_item.first = first_byte;
    assign take          = held_valid && advance;
    assign out_byte      = out_res.data;
    assign kind          = out_res.kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_limit_reg <= '1;
            fwd_reg        <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_SIZE_LIMIT:   size_limit_reg <= cfg_data;
                REG_FWD_TRAILERS: fwd_reg        <= cfg_data[0];
                default:          fwd_reg        <= fwd_reg;
            endcase
        end
    end

    hcd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    hcd_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .take             (take),
        .item             (held_item),
        .size_limit       (size_limit_reg),
        .forward_trailers (fwd_reg),
        .res_valid        (res_valid),
        .res              (res),
        .phase            (phase)
    );

    hcd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && res_valid),
        .res       (res),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    // a draining output never holds back the input side
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    // after an error or completion nothing comes out until a new body starts
    a_quiet_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        take && !held_item.first && (phase == PH_ERROR || phase == PH_DONE)
        |=> $stable(out_res) || !out_valid || $past(out_ready))
        else $error("result produced after end of message");

    a_no_result_when_ended: assert property (@(posedge clk) disable iff (!rst_n)
        take && !held_item.first && (phase == PH_ERROR || phase == PH_DONE) |-> !res_valid)
        else $error("parser emitted a result in a terminal phase");

    // status-only kinds carry a zero byte
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res.kind == K_LINE_END || res.kind == K_COMPLETE
                      || res.kind == K_FRAMING || res.kind == K_OVER)
        |-> res.data == 8'd0)
        else $error("status result with nonzero byte");

endmodule

/* tb/sv/tb_http_chunked_deframer.sv */
`timescale 1ns / 1ps

module tb_http_chunked_deframer;

    import hcd_pkg::*;

    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [7:0] b;
        logic       f;
        logic       typed;
        logic       has;
        kind_t      rk;
        logic [7:0] rd;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [0:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [7:0]            in_byte;
    logic                  first_byte;
    logic                  out_valid;
    logic                  out_ready;
    logic [7:0]            out_byte;
    kind_t                 kind;

    // predictor state and its copy of the registers
    phase_t      parse_phase = PH_SIZE;
    logic [31:0] chunk_left  = '0;
    logic [3:0]  digit_count = '0;
    logic        line_blank  = 1'b1;
    logic [31:0] limit_reg   = 32'hFFFF_FFFF;
    logic        fwd_reg     = 1'b1;

    result_t     pending_results[$];
    logic [7:0]  msg_q[$];
    dir_row_t    dir_rows[$];

    // fixed expectation of the item on the wire, for typed table rows
    logic        row_typed = 1'b0;
    logic        row_has   = 1'b0;
    result_t     row_res   = '0;

    int          send_idle_pct = 7;
    int          recv_idle_pct = 69;
    int          hold_left     = 0;
    int          stall_cycles  = 0;
    int          mismatch_count = 0;

    http_chunked_deframer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .first_byte (first_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .kind       (kind)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return c - "a" + 10;
        if (c >= "A" && c <= "F")
            return c - "A" + 10;
        return -1;
    endfunction

    // advances the parser copy by one byte, returns 1 when a result is due
    function automatic logic deframe_step(input logic [7:0] c, input logic restart,
                                          output result_t res);
        int         d;
        logic [63:0] grown;
        logic        hit;
        hit = 1'b0;
        res.data = 8'h00;
        res.kind = K_PAYLOAD;
        if (restart)
        begin
            parse_phase = PH_SIZE;
            chunk_left  = '0;
            digit_count = '0;
            line_blank  = 1'b1;
        end
        case (parse_phase)
            PH_SIZE:
            begin
                d = hex_nibble(c);
                if (d >= 0)
                begin
                    if (chunk_left > (limit_reg >> 4))
                    begin
                        parse_phase = PH_ERROR;
                        res.kind = K_OVER;
                        hit = 1'b1;
                    end
                    else
                    begin
                        grown = ({32'h0, chunk_left} << 4) | 64'(d);
                        chunk_left = grown[31:0];
                        if (chunk_left > limit_reg)
                        begin
                            parse_phase = PH_ERROR;
                            res.kind = K_OVER;
                            hit = 1'b1;
                        end
                        else if (digit_count < 4'd15)
                        begin
                            digit_count = digit_count + 4'd1;
                        end
                    end
                end
                else if (digit_count == 0 ||
                         !(c == CH_SP || c == CH_TAB || c == CH_SEMI || c == CH_CR))
                begin
                    parse_phase = PH_ERROR;
                    res.kind = K_FRAMING;
                    hit = 1'b1;
                end
                else if (c == CH_CR)
                begin
                    parse_phase = PH_HDR_LF;
                end
                else
                begin
                    parse_phase = PH_EXT;
                end
            end
            PH_EXT:
            begin
                if (c == CH_CR)
                    parse_phase = PH_HDR_LF;
            end
            PH_HDR_LF:
            begin
                if (c != CH_LF)
                begin
                    parse_phase = PH_ERROR;
                    res.kind = K_FRAMING;
                    hit = 1'b1;
                end
                else if (chunk_left == 0)
                begin
                    parse_phase = PH_TRAILER;
                    line_blank = 1'b1;
                end
                else
                begin
                    parse_phase = PH_DATA;
                end
            end
            PH_DATA:
            begin
                chunk_left = chunk_left - 32'd1;
                if (chunk_left == 0)
                    parse_phase = PH_DATA_CR;
                res.data = c;
                hit = 1'b1;
            end
            PH_DATA_CR:
            begin
                if (c != CH_CR)
                begin
                    parse_phase = PH_ERROR;
                    res.kind = K_FRAMING;
                    hit = 1'b1;
                end
                else
                begin
                    parse_phase = PH_DATA_LF;
                end
            end
            PH_DATA_LF:
            begin
                if (c != CH_LF)
                begin
                    parse_phase = PH_ERROR;
                    res.kind = K_FRAMING;
                    hit = 1'b1;
                end
                else
                begin
                    parse_phase = PH_SIZE;
                    chunk_left  = '0;
                    digit_count = '0;
                end
            end
            PH_TRAILER:
            begin
                if (c == CH_CR)
                begin
                    parse_phase = PH_TRL_LF;
                end
                else
                begin
                    line_blank = 1'b0;
                    if (fwd_reg)
                    begin
                        res.data = c;
                        res.kind = K_TRAILER;
                        hit = 1'b1;
                    end
                end
            end
            PH_TRL_LF:
            begin
                if (c != CH_LF)
                begin
                    parse_phase = PH_ERROR;
                    res.kind = K_FRAMING;
                    hit = 1'b1;
                end
                else if (line_blank)
                begin
                    parse_phase = PH_DONE;
                    res.kind = K_COMPLETE;
                    hit = 1'b1;
                end
                else
                begin
                    line_blank = 1'b1;
                    parse_phase = PH_TRAILER;
                    if (fwd_reg)
                    begin
                        res.kind = K_LINE_END;
                        hit = 1'b1;
                    end
                end
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
        return hit;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : scoreboard
        result_t predicted;
        result_t want;
        logic    hit;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                hit = deframe_step(in_byte, first_byte, predicted);
                if (row_typed)
                begin
                    hit = row_has;
                    predicted = row_res;
                end
                if (hit)
                    pending_results.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result byte %02h kind %0d",
                                              out_byte, kind));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  out_byte, want.data));
                    if (kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  kind, want.kind));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // receiver: random back-pressure plus an optional long hold-off
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic f, input logic typed,
                             input logic has, input result_t res);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        in_byte    = b;
        first_byte = f;
        row_typed  = typed;
        row_has    = has;
        row_res    = res;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] v);
        wait_idle();
        // bytes that give no result may still be in the pipeline
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_SIZE_LIMIT)
            limit_reg = v;
        else
            fwd_reg = v[0];
    endtask

    function automatic logic [7:0] any_byte();
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = any_byte();
        if (b == CH_CR)
            b = CH_SP;
        return b;
    endfunction

    task automatic push_hex(input logic [35:0] v, input int lead);
        int         n;
        logic [3:0] nib;
        n = 1;
        while (n < 9 && (v >> (4 * n)) != 0)
            n++;
        repeat (lead) msg_q.push_back("0");
        for (int i = n - 1; i >= 0; i--)
        begin
            nib = v[4 * i +: 4];
            if (nib < 10)
                msg_q.push_back(8'h30 + 8'(nib));
            else if ($urandom_range(1))
                msg_q.push_back(8'h41 + 8'(nib) - 8'd10);
            else
                msg_q.push_back(8'h61 + 8'(nib) - 8'd10);
        end
    endtask

    task automatic push_ext();
        if ($urandom_range(3) == 0)
        begin
            case ($urandom_range(2))
                0: msg_q.push_back(CH_SP);
                1: msg_q.push_back(CH_TAB);
                default: msg_q.push_back(CH_SEMI);
            endcase
            repeat ($urandom_range(0, 4)) msg_q.push_back(text_byte());
        end
    endtask

    // one chunked body, mostly well formed, sometimes damaged or cut short
    task automatic send_message(inout int sent);
        logic [35:0] sz;
        int          r;
        int          idx;
        int          cut;
        logic        stop;
        result_t     none;
        none = '0;
        stop = 1'b0;
        msg_q.delete();
        if ($urandom_range(99) < 5)
        begin
            repeat ($urandom_range(1, 5)) msg_q.push_back(any_byte());
        end
        else
        begin
            for (int i = $urandom_range(0, 3); i > 0 && !stop; i--)
            begin
                r = $urandom_range(99);
                if (r < 70)
                    sz = 36'($urandom_range(1, 6));
                else if (r < 85)
                    sz = 36'($urandom_range(7, 40));
                else if (r < 93)
                    sz = (limit_reg < 64) ? 36'(limit_reg + $urandom_range(0, 1))
                                          : 36'($urandom_range(1, 3));
                else
                    sz = {4'($urandom_range(15)), $urandom};
                if (sz == 0)
                    sz = 1;
                push_hex(sz, ($urandom_range(9) == 0) ? $urandom_range(1, 16) : 0);
                push_ext();
                msg_q.push_back(CH_CR);
                msg_q.push_back(CH_LF);
                if (sz > 64 || sz > limit_reg)
                begin
                    // too big to send whole: a few bytes, then the next body restarts
                    repeat (3) msg_q.push_back(any_byte());
                    stop = 1'b1;
                end
                else
                begin
                    repeat (sz) msg_q.push_back(any_byte());
                    msg_q.push_back(CH_CR);
                    msg_q.push_back(CH_LF);
                end
            end
            if (!stop)
            begin
                push_hex(36'h0, $urandom_range(0, 2));
                push_ext();
                msg_q.push_back(CH_CR);
                msg_q.push_back(CH_LF);
                repeat ($urandom_range(0, 2))
                begin
                    repeat ($urandom_range(1, 6)) msg_q.push_back(text_byte());
                    msg_q.push_back(CH_CR);
                    msg_q.push_back(CH_LF);
                end
                msg_q.push_back(CH_CR);
                msg_q.push_back(CH_LF);
            end
            if ($urandom_range(99) < 15)
            begin
                idx = $urandom_range(msg_q.size() - 1);
                case ($urandom_range(3))
                    0: msg_q[idx] = any_byte();
                    1: msg_q[idx] = CH_CR;
                    2: msg_q[idx] = CH_LF;
                    default: msg_q[idx] = "g";
                endcase
            end
            if ($urandom_range(99) < 5)
            begin
                cut = $urandom_range(1, msg_q.size());
                while (msg_q.size() > cut)
                    void'(msg_q.pop_back());
            end
        end
        for (int i = 0; i < msg_q.size(); i++)
            send_byte(msg_q[i], (i == 0) && ($urandom_range(19) != 0), 1'b0, 1'b0, none);
        sent += msg_q.size();
        // trailing bytes after the body, normally ignored by the parser
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 3)) send_byte(any_byte(), 1'b0, 1'b0, 1'b0, none);
    endtask

    task automatic run_phase(input logic [31:0] lim, input logic fwd, input int s_idle,
                             input int r_idle, input int quota, input logic pressure);
        int sent;
        int nmsg;
        write_reg(REG_SIZE_LIMIT, lim);
        write_reg(REG_FWD_TRAILERS, {31'h0, fwd});
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        if (pressure)
            hold_left = HOLD_CYCLES;
        sent = 0;
        nmsg = 0;
        while (sent < quota)
        begin
            send_message(sent);
            nmsg++;
            if (pressure && nmsg % 5 == 0)
                wait_idle();
        end
    endtask

    task automatic add_row(input logic [7:0] b, input logic f, input logic typed,
                           input logic has, input kind_t k, input logic [7:0] d);
        dir_row_t row;
        row.b     = b;
        row.f     = f;
        row.typed = typed;
        row.has   = has;
        row.rk    = k;
        row.rd    = d;
        dir_rows.push_back(row);
    endtask

    initial
    begin : main_seq
        result_t res;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_byte    = 8'h00;
        first_byte = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        //       byte    first typed has kind        data
        add_row("g",     1'b1, 1'b1, 1'b1, K_FRAMING,  8'h00);  // no size digits
        add_row("1",     1'b1, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row(CH_SP,   1'b0, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row(CH_CR,   1'b0, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row(CH_LF,   1'b0, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row(8'hFF,   1'b0, 1'b1, 1'b1, K_PAYLOAD,  8'hFF);
        add_row(CH_CR,   1'b0, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row(CH_LF,   1'b0, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row("2",     1'b0, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row(CH_TAB,  1'b0, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row(CH_CR,   1'b0, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row(CH_LF,   1'b0, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row(8'h00,   1'b0, 1'b1, 1'b1, K_PAYLOAD,  8'h00);
        add_row("Z",     1'b0, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row("Q",     1'b0, 1'b1, 1'b1, K_FRAMING,  8'h00);  // no CR after data
        add_row("7",     1'b0, 1'b1, 1'b0, K_PAYLOAD,  8'h00);  // ignored after error
        add_row("0",     1'b1, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row(CH_CR,   1'b0, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row("Q",     1'b0, 1'b1, 1'b1, K_FRAMING,  8'h00);  // no LF after CR
        add_row("0",     1'b1, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row(CH_CR,   1'b0, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row(CH_LF,   1'b0, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row("k",     1'b0, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row(CH_CR,   1'b0, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row(CH_LF,   1'b0, 1'b1, 1'b1, K_LINE_END, 8'h00);
        add_row(CH_CR,   1'b0, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row(CH_LF,   1'b0, 1'b1, 1'b1, K_COMPLETE, 8'h00);
        add_row("0",     1'b1, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row(CH_CR,   1'b0, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row(CH_LF,   1'b0, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row(CH_CR,   1'b0, 1'b0, 1'b0, K_PAYLOAD,  8'h00);
        add_row("b",     1'b0, 1'b1, 1'b1, K_FRAMING,  8'h00);  // trailer CR without LF

        send_idle_pct = 7;
        recv_idle_pct = 69;
        foreach (dir_rows[i])
        begin
            res.data = dir_rows[i].rd;
            res.kind = dir_rows[i].rk;
            send_byte(dir_rows[i].b, dir_rows[i].f, dir_rows[i].typed, dir_rows[i].has, res);
        end

        run_phase(32'hFFFF_FFFF, 1'b1, 7, 69, 130, 1'b0);
        run_phase(32'h0000_0000, 1'b0, 7, 69, 130, 1'b0);
        run_phase($urandom_range(1, 48), 1'b1, 69, 7, 130, 1'b0);
        run_phase($urandom, 1'b0, 69, 7, 130, 1'b0);
        run_phase(32'd40, 1'b1, 0, 0, 150, 1'b1);
        run_phase(32'hFFFF_FFFF, 1'b1, 0, 0, 130, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES * 2) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* http_chunked_deframer.f */
src/hcd_pkg.sv
src/hcd_in_reg.sv
src/hcd_parser.sv
src/hcd_out_reg.sv
src/http_chunked_deframer.sv
tb/sv/tb_http_chunked_deframer.sv
